FILE: sv/fpba_pkg.sv
`timescale 1ns / 1ps

package fpba_pkg;

    // Operation codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Fit policies
    localparam logic [1:0] POL_BEST  = 2'd0;
    localparam logic [1:0] POL_FIRST = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_GRANTED  = 2'd0;
    localparam logic [1:0] STAT_NOFIT    = 2'd1;
    localparam logic [1:0] STAT_LOADED   = 2'd2;
    localparam logic [1:0] STAT_REJECTED = 2'd3;

    typedef struct packed {
        logic        func;
        logic [3:0]  block_index;
        logic [31:0] block_size;
        logic [31:0] block_used;
        logic [31:0] request_size;
        logic [1:0]  policy;
    } fpba_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_block;
        logic [31:0] remaining_free;
    } fpba_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } fpba_state_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic scan_adv;
        logic finish;
    } fpba_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic is_alloc;
        logic scan_none;
        logic scan_last;
        logic out_free;
    } fpba_sts_t;

endpackage

FILE: sv/fpba_if.sv
`timescale 1ns / 1ps

interface fpba_cmd_if
    import fpba_pkg::*;
();
    logic      valid;
    logic      ready;
    fpba_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpba_rsp_if
    import fpba_pkg::*;
();
    logic      valid;
    logic      ready;
    fpba_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/fit_policy_block_allocator.sv
`timescale 1ns / 1ps

// Contiguous block allocator with best, first and worst fit policies. A load
// transfer (func 0) sets the free space of one table entry to size minus used,
// or is rejected when used exceeds size; an allocate transfer (func 1) scans
// entries 0 .. min(num_blocks, MAX_BLOCKS)-1, picks the fitting entry by policy
// (ties to the lowest index), takes the request out of it and returns the index.
// One command is in flight at a time. A load passes from dispatch to finish; an
// allocation passes through dispatch, a scan, a drain and finish, the scan paced
// by the free-space RAM read port, which delivers one entry per cycle. A policy
// code of 3 or an empty table answers no-fit straight from dispatch. The result
// sits in an output register, so a new command can be taken while the previous
// result waits for its transfer. Entries are never cleared: allocate only over
// entries that were loaded. The user writes num_blocks through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.

module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    fpba_cmd_if.sink   cmd,
    fpba_rsp_if.source rsp
);

    fpba_ctl_t ctl;
    fpba_sts_t sts;

    // Sequence load, scan, drain and finish steps
    fpba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    // Hold the command, the table RAM, the fit compare and the result register
    fpba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

FILE: sv/fpba_ram.sv
`timescale 1ns / 1ps

module fpba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fpba_ctrl.sv
`timescale 1ns / 1ps

module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  fpba_sts_t sts,
    output fpba_ctl_t ctl
);

    fpba_state_t state_reg;
    fpba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl.in_ready = 1'b0;
        ctl.scan_adv = 1'b0;
        ctl.finish   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!sts.is_alloc || sts.scan_none)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_adv = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the result register can take the transfer
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/fpba_dp.sv
`timescale 1ns / 1ps

module fpba_dp
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    fpba_cmd_if.sink    cmd,
    fpba_rsp_if.source  rsp,
    input  fpba_ctl_t   ctl,
    output fpba_sts_t   sts
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [4:0]       num_blocks_reg;
    fpba_cmd_t        item_reg;
    logic [IDX_W-1:0] scan_cnt_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_free_reg;
    logic             out_vld_reg;
    fpba_rsp_t        out_data_reg;

    logic [CNT_W-1:0] limit;
    logic             accept;
    logic             load_ok;
    logic             policy_ok;
    logic [31:0]      rd_data;
    logic             fits;
    logic             take;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic [31:0]      grant_rem;
    fpba_rsp_t        res;

    assign accept    = cmd.valid && ctl.in_ready;
    assign cmd.ready = ctl.in_ready;

    always_comb
    begin
        if (int'(num_blocks_reg) > MAX_BLOCKS)
        begin
            limit = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            limit = CNT_W'(num_blocks_reg);
        end
    end

    assign load_ok   = (item_reg.block_used <= item_reg.block_size)
                       && (int'(item_reg.block_index) < MAX_BLOCKS);
    assign policy_ok = (item_reg.policy == POL_BEST) || (item_reg.policy == POL_FIRST)
                       || (item_reg.policy == POL_WORST);

    assign sts.in_valid  = cmd.valid;
    assign sts.is_alloc  = (item_reg.func == FUNC_ALLOC);
    assign sts.scan_none = (limit == '0) || !policy_ok;
    assign sts.scan_last = ((CNT_W'(scan_cnt_reg) + CNT_W'(1)) == limit);
    assign sts.out_free  = !out_vld_reg || rsp.ready;

    // Compare the entry read last cycle against the current pick
    assign fits = (rd_data >= item_reg.request_size);
    always_comb
    begin
        take = 1'b0;
        if (cmp_vld_reg && fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (item_reg.policy == POL_BEST)
            begin
                take = (rd_data < best_free_reg);
            end
            else if (item_reg.policy == POL_WORST)
            begin
                take = (rd_data > best_free_reg);
            end
        end
    end

    assign grant_rem = best_free_reg - item_reg.request_size;

    always_comb
    begin
        res       = '0;
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = grant_rem;
        if (item_reg.func == FUNC_LOAD)
        begin
            res.chosen_block = item_reg.block_index;
            ram_waddr        = IDX_W'(item_reg.block_index);
            ram_wdata        = item_reg.block_size - item_reg.block_used;
            if (load_ok)
            begin
                res.status         = STAT_LOADED;
                res.remaining_free = ram_wdata;
                ram_we             = ctl.finish;
            end
            else
            begin
                res.status = STAT_REJECTED;
            end
        end
        else if (found_reg)
        begin
            res.status         = STAT_GRANTED;
            res.chosen_block   = 4'(best_idx_reg);
            res.remaining_free = grant_rem;
            ram_we             = ctl.finish;
        end
        else
        begin
            res.status = STAT_NOFIT;
        end
    end

    fpba_ram #(
        .WIDTH (32),
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.scan_adv),
        .raddr (scan_cnt_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            scan_cnt_reg   <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_blocks_reg <= cfg_wdata;
            end
            cmp_vld_reg <= ctl.scan_adv;
            if (accept)
            begin
                found_reg    <= 1'b0;
                scan_cnt_reg <= '0;
            end
            else
            begin
                if (ctl.scan_adv)
                begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctl.finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd.data;
        end
        cmp_idx_reg <= scan_cnt_reg;
        if (take)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_free_reg <= rd_data;
        end
        if (ctl.finish)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;

endmodule

FILE: sv/fpba_chk.sv
`timescale 1ns / 1ps

module fpba_chk
    import fpba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input fpba_rsp_t rsp_data
);

    // One command at a time: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while another is in flight");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled result changed");

    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status == STAT_NOFIT))
        |-> ((rsp_data.chosen_block == 4'd0) && (rsp_data.remaining_free == 32'd0)))
        else $error("no-fit result carries index or space");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status == STAT_REJECTED))
        |-> (rsp_data.remaining_free == 32'd0))
        else $error("rejected load reports free space");

endmodule

bind fit_policy_block_allocator fpba_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
